// ----- hw/rtl/fd_pkg.sv -----
package fd_pkg;

  // Storage sizes of the block.
  localparam int MAX_TAPS       = 256;
  localparam int MAX_DECIMATION = 16;

  // Field widths of the input beats, the result beats and the configuration port.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int TAP_IN_W   = 8;
  localparam int OUT_W      = 20;
  localparam int DEC_CFG_W  = 5;
  localparam int TAPS_CFG_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Derived widths.
  localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int PH_W       = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + TAP_IDX_W;
  localparam int FRAC_SHIFT = 17;
  localparam int QUOT_W     = ACC_W - FRAC_SHIFT;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes of an input beat.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [DEC_CFG_W-1:0]  DEC_RESET  = 5'd4;
  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 9'd193;

  // One decoded work item passed from the front to the back.
  typedef struct packed {
    logic                        is_coef;
    logic                        emit;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [TAP_IDX_W-1:0]        tap_idx;
    logic signed [COEF_W-1:0]    coef;
    logic [TAP_CNT_W-1:0]        taps;
  } fd_item_t;

  // Sequencer states of the back.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fd_state_t;

endpackage

// ----- hw/rtl/fd_queue.sv -----
module fd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fd_pkg::fd_item_t push_item,
  output logic             full,
  input  logic             pop,
  output fd_pkg::fd_item_t head_item,
  output logic             empty
);
  import fd_pkg::*;

  fd_item_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // The front must never push into a full queue or pop an empty one.
  assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// ----- hw/rtl/fd_front.sv -----
module fd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [fd_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [fd_pkg::TAP_IN_W-1:0]        in_tap_index,
  input  logic signed [fd_pkg::COEF_W-1:0]   in_tap_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                               q_push,
  output fd_pkg::fd_item_t                   q_item,
  input  logic                               q_full
);
  import fd_pkg::*;

  logic [DEC_CFG_W-1:0]  dec_cfg_r, dec_cfg_nxt;
  logic [TAPS_CFG_W-1:0] taps_cfg_r, taps_cfg_nxt;
  logic [PH_W-1:0]       phase_r, phase_nxt;
  logic [PH_W-1:0]       phase_reload;
  logic [TAP_CNT_W-1:0]  taps_eff;
  logic                  in_beat;
  logic                  is_coef;
  logic                  idx_ok;
  logic                  emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_beat   = in_valid && in_ready;
  assign is_coef   = (in_command == CMD_COEF);
  assign idx_ok    = (32'(in_tap_index) < MAX_TAPS);
  assign emit      = (phase_r == '0);

  // Register writes; indexes beyond the list are ignored.
  always_comb begin
    dec_cfg_nxt  = dec_cfg_r;
    taps_cfg_nxt = taps_cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECIMATION: dec_cfg_nxt  = cfg_data[DEC_CFG_W-1:0];
        CFG_TAP_COUNT:  taps_cfg_nxt = cfg_data[TAPS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration into the supported ranges.
  always_comb begin
    if (dec_cfg_r == '0) begin
      phase_reload = '0;
    end else if (32'(dec_cfg_r) > MAX_DECIMATION) begin
      phase_reload = PH_W'(MAX_DECIMATION - 1);
    end else begin
      phase_reload = PH_W'(dec_cfg_r - 1'b1);
    end
    if (taps_cfg_r == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (32'(taps_cfg_r) > MAX_TAPS) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = TAP_CNT_W'(taps_cfg_r);
    end
  end

  // Phase counter: reload on an output sample, count down otherwise.
  always_comb begin
    phase_nxt = phase_r;
    if (in_beat && !is_coef) begin
      phase_nxt = emit ? phase_reload : phase_r - 1'b1;
    end
  end

  // Classify the beat; out-of-range coefficient writes are dropped here.
  always_comb begin
    q_push         = in_beat && (!is_coef || idx_ok);
    q_item.is_coef = is_coef;
    q_item.emit    = !is_coef && emit;
    q_item.sample  = in_sample_value;
    q_item.tap_idx = TAP_IDX_W'(in_tap_index);
    q_item.coef    = in_tap_value;
    q_item.taps    = taps_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_cfg_r  <= DEC_RESET;
      taps_cfg_r <= TAPS_RESET;
      phase_r    <= '0;
    end else begin
      dec_cfg_r  <= dec_cfg_nxt;
      taps_cfg_r <= taps_cfg_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

// ----- hw/rtl/fd_mac.sv -----
module fd_mac (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fd_pkg::fd_item_t                head_item,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [fd_pkg::OUT_W-1:0] out_filtered_value
);
  import fd_pkg::*;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  fd_state_t state_r, state_nxt;

  // Sample history ring and coefficient store.
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];

  logic [TAP_IDX_W-1:0]       wptr_r, wptr_nxt;
  logic [TAP_IDX_W-1:0]       newest_r, newest_nxt;
  logic [TAP_CNT_W-1:0]       fill_r, fill_nxt;
  logic [TAP_CNT_W-1:0]       taps_r, taps_nxt;
  logic [TAP_CNT_W-1:0]       j_r, j_nxt;
  logic [TAP_IDX_W-1:0]       j_idx;
  logic [TAP_IDX_W:0]         addr_diff;
  logic [TAP_IDX_W-1:0]       hist_raddr;

  // Multiply-accumulate pipeline.
  logic                       rd_vld_r;
  logic                       live_r;
  logic signed [SAMPLE_W-1:0] hist_q_r;
  logic signed [COEF_W-1:0]   coef_q_r;
  logic signed [SAMPLE_W-1:0] hist_op;
  logic                       prod_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic [QUOT_W-1:0]          quot;
  logic [QUOT_W-OUT_W:0]      quot_top;
  logic signed [OUT_W-1:0]    sat_value;

  // Output register.
  logic                       out_vld_r, out_vld_nxt;
  logic signed [OUT_W-1:0]    out_data_r;

  // Sequencer controls.
  logic hist_we;
  logic coef_we;
  logic issue;
  logic pipe_empty;
  logic out_free;
  logic out_load;
  logic last_tap;

  assign pipe_empty = !rd_vld_r && !prod_vld_r;
  assign out_free   = !out_vld_r || out_ready;
  assign j_idx      = j_r[TAP_IDX_W-1:0];
  assign last_tap   = (j_r == taps_r - TAP_CNT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && !head_item.is_coef && head_item.emit) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = 1'b0;
    hist_we  = 1'b0;
    coef_we  = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_pop   = !q_empty;
        hist_we = !q_empty && !head_item.is_coef;
        coef_we = !q_empty && head_item.is_coef;
      end
      ST_RUN: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
        out_load = pipe_empty && out_free;
      end
      default: ;
    endcase
  end

  // History pointer, fill count and tap counter.
  always_comb begin
    wptr_nxt   = wptr_r;
    newest_nxt = newest_r;
    fill_nxt   = fill_r;
    taps_nxt   = taps_r;
    j_nxt      = j_r;
    if (hist_we) begin
      wptr_nxt   = (wptr_r == TAP_IDX_W'(MAX_TAPS - 1)) ? '0 : wptr_r + 1'b1;
      newest_nxt = wptr_r;
      if (fill_r != TAP_CNT_W'(MAX_TAPS)) begin
        fill_nxt = fill_r + 1'b1;
      end
      taps_nxt = head_item.taps;
      j_nxt    = '0;
    end else if (issue) begin
      j_nxt = j_r + 1'b1;
    end
  end

  // Tap j reads the sample j places older than the newest one.
  always_comb begin
    addr_diff = {1'b0, newest_r} - {1'b0, j_idx};
    if (addr_diff[TAP_IDX_W]) begin
      hist_raddr = TAP_IDX_W'(addr_diff + (TAP_IDX_W+1)'(MAX_TAPS));
    end else begin
      hist_raddr = addr_diff[TAP_IDX_W-1:0];
    end
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wptr_r] <= head_item.sample;
    end
    hist_q_r <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[head_item.tap_idx] <= head_item.coef;
    end
    coef_q_r <= coef_mem[j_idx];
  end

  // Slots never written since reset count as zero samples.
  assign hist_op = live_r ? hist_q_r : '0;

  always_ff @(posedge clk) begin
    prod_r <= hist_op * coef_q_r;
  end

  // Accumulate; every sample written to the history clears the sum.
  always_comb begin
    acc_nxt = acc_r;
    if (hist_we) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Floor shift to Q5.15 and saturate.
  always_comb begin
    quot     = acc_r[ACC_W-1:FRAC_SHIFT];
    quot_top = quot[QUOT_W-1:OUT_W-1];
    if ((&quot_top) || !(|quot_top)) begin
      sat_value = quot[OUT_W-1:0];
    end else if (quot[QUOT_W-1]) begin
      sat_value = OUT_MIN;
    end else begin
      sat_value = OUT_MAX;
    end
  end

  // Output register holds a result until it is taken.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= sat_value;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_filtered_value = out_data_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wptr_r     <= '0;
      newest_r   <= '0;
      fill_r     <= '0;
      taps_r     <= TAP_CNT_W'(1);
      j_r        <= '0;
      rd_vld_r   <= 1'b0;
      live_r     <= 1'b0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wptr_r     <= wptr_nxt;
      newest_r   <= newest_nxt;
      fill_r     <= fill_nxt;
      taps_r     <= taps_nxt;
      j_r        <= j_nxt;
      rd_vld_r   <= issue;
      live_r     <= issue && (j_r < fill_r);
      prod_vld_r <= rd_vld_r;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // A result is loaded only after the last product has been summed.
  assert property (@(posedge clk) disable iff (!rst_n) out_load |-> pipe_empty)
    else $error("result loaded while products are in flight");
  // The tap counter stays within the active tap count while running.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_RUN) |-> (j_r < taps_r && taps_r != '0))
    else $error("tap counter out of range");
  // The history fill count never passes the ring size.
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= TAP_CNT_W'(MAX_TAPS))
    else $error("history fill count overflow");
  // A finished result waiting at the output is not overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_vld_r && !out_ready) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

// ----- hw/rtl/fir_decimator_top.sv -----
// Decimating FIR filter. Each input beat either writes one Q1.17 coefficient
// (command 1) or delivers one Q1.15 sample (command 0). Every decimation_factor-th
// sample, starting with the first after reset, yields one Q5.15 result: the sum
// over the newest tap_count samples times coefficients 0 upward, floored and
// saturated to 20 bits. Coefficients in use must be written first. Input beats
// enter a four-entry queue, so the block keeps taking beats while it computes
// or while a result waits on the output, until the queue fills. The back end
// does one multiply-accumulate per cycle on a history ring and coefficient
// store with separate read and write ports; a sample that produces a result
// holds it until its taps are issued, read, multiplied and summed and the output
// register is free; any other beat is simply stored. Configuration writes are
// taken at any time but must only be made while the block is idle.
module fir_decimator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [fd_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [fd_pkg::TAP_IN_W-1:0]        in_tap_index,
  input  logic signed [fd_pkg::COEF_W-1:0]   in_tap_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fd_pkg::OUT_W-1:0]    out_filtered_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fd_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  fd_item_t q_in_item;
  fd_item_t q_head_item;

  // Front: configuration, phase tracking and beat classification.
  fd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_sample_value (in_sample_value),
    .in_tap_index    (in_tap_index),
    .in_tap_value    (in_tap_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_push          (q_push),
    .q_item          (q_in_item),
    .q_full          (q_full)
  );

  // Work queue between front and back.
  fd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head_item),
    .empty     (q_empty)
  );

  // Back: storage, multiply-accumulate and output register.
  fd_mac u_mac (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_item          (q_head_item),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fd_pkg::*;

  // Index with no register behind it; writes to it must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = MAX_TAPS + 44;
  localparam int LONG_HOLD     = 400;

  // One input beat as offered on the in_ channel.
  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TAP_IN_W-1:0]        tidx;
    logic signed [COEF_W-1:0]   tval;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_command = CMD_SAMPLE;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic [TAP_IN_W-1:0]        in_tap_index = '0;
  logic signed [COEF_W-1:0]   in_tap_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_W-1:0]    out_filtered_value;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  fir_decimator_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_sample_value    (in_sample_value),
    .in_tap_index       (in_tap_index),
    .in_tap_value       (in_tap_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Shadow of the filter state, advanced on every accepted beat.
  logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
  logic signed [COEF_W-1:0]   coefs [MAX_TAPS];
  logic [PH_W-1:0]            phase_cnt = '0;
  logic [DEC_CFG_W-1:0]       dec_reg = DEC_RESET;
  logic [TAPS_CFG_W-1:0]      taps_reg = TAPS_RESET;
  logic signed [OUT_W-1:0]    want_filtered [$];

  // Beats waiting to be offered, and which coefficients they have loaded so far.
  beat_t send_q [$];
  logic  coef_loaded [MAX_TAPS];

  int  beats_pushed = 0;
  int  beats_offered = 0;
  int  beats_taken = 0;
  int  coef_beats = 0;
  int  results_seen = 0;
  int  sat_hits = 0;
  int  cfg_writes = 0;
  int  errors = 0;
  int  cycle_cnt = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  bit  rx_hold_req = 1'b0;
  bit  idle_on = 1'b1;

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      history[i] = '0;
      coefs[i] = '0;
      coef_loaded[i] = 1'b0;
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Register values as the datapath uses them, out-of-range settings clamped.
  function automatic int eff_dec();
    if (dec_reg == 0) return 1;
    if (dec_reg > MAX_DECIMATION) return MAX_DECIMATION;
    return int'(dec_reg);
  endfunction

  function automatic int eff_taps();
    if (taps_reg == 0) return 1;
    if (taps_reg > MAX_TAPS) return MAX_TAPS;
    return int'(taps_reg);
  endfunction

  // Apply one accepted beat to the shadow state and queue any filtered value it yields.
  function automatic void filter_beat(input logic cmd, input logic signed [SAMPLE_W-1:0] s,
                                      input logic [TAP_IN_W-1:0] ti,
                                      input logic signed [COEF_W-1:0] tv);
    longint acc;
    longint q;
    int     n;
    if (cmd == CMD_COEF) begin
      coefs[ti] = tv;
      return;
    end
    for (int j = MAX_TAPS - 1; j > 0; j--) history[j] = history[j-1];
    history[0] = s;
    if (phase_cnt != 0) begin
      phase_cnt = phase_cnt - 1'b1;
      return;
    end
    phase_cnt = PH_W'(eff_dec() - 1);
    n = eff_taps();
    acc = 0;
    for (int j = 0; j < n; j++) acc += longint'(history[j]) * longint'(coefs[j]);
    // Arithmetic shift floors toward minus infinity, then clip to 20 bits.
    q = acc >>> FRAC_SHIFT;
    if (q > 524287) begin
      q = 524287;
      sat_hits++;
    end else if (q < -524288) begin
      q = -524288;
      sat_hits++;
    end
    want_filtered.push_back(OUT_W'(q));
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles without finishing", $time, cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Input side: offer queued beats, holding each until its handshake completes.
  always @(negedge clk) begin : send_side
    beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && beats_taken != beats_offered) begin
      // The current beat is still waiting.
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (send_q.size() > 0) begin
      b = send_q.pop_front();
      in_command <= b.cmd;
      in_sample_value <= b.sample;
      in_tap_index <= b.tidx;
      in_tap_value <= b.tval;
      in_valid <= 1'b1;
      beats_offered++;
      if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 14);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin : recv_side
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Track accepted input beats and register writes.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      filter_beat(in_command, in_sample_value, in_tap_index, in_tap_value);
      beats_taken++;
      if (in_command == CMD_COEF) coef_beats++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      cfg_writes++;
      case (cfg_index)
        CFG_DECIMATION: dec_reg = cfg_data[DEC_CFG_W-1:0];
        CFG_TAP_COUNT:  taps_reg = cfg_data[TAPS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare each result beat with the oldest outstanding filtered value.
  always @(posedge clk) begin : result_check
    logic signed [OUT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (want_filtered.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %0d",
                 $time, out_filtered_value);
      end else begin
        want = want_filtered.pop_front();
        if (out_filtered_value !== want) begin
          errors++;
          $display("%0t: filtered_value mismatch, expected %0d, got %0d",
                   $time, want, out_filtered_value);
        end
      end
    end
  end

  function automatic beat_t random_beat();
    beat_t b;
    b.cmd = 1'($urandom_range(0, 1));
    b.sample = SAMPLE_W'($urandom);
    b.tidx = TAP_IN_W'($urandom);
    b.tval = COEF_W'($urandom);
    return b;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 18'sh1FFFF;
      1: return 18'sh20000;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic push_coef(input int idx, input logic signed [COEF_W-1:0] val);
    beat_t b;
    b = random_beat();
    b.cmd = CMD_COEF;
    b.tidx = TAP_IN_W'(idx);
    b.tval = val;
    coef_loaded[idx] = 1'b1;
    send_q.push_back(b);
    beats_pushed++;
  endtask

  // Every coefficient in use is loaded before the sample that might read it.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    beat_t b;
    int    n;
    n = eff_taps();
    for (int j = 0; j < n; j++)
      if (!coef_loaded[j]) push_coef(j, rand_coef());
    b = random_beat();
    b.cmd = CMD_SAMPLE;
    b.sample = s;
    send_q.push_back(b);
    beats_pushed++;
  endtask

  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) push_coef($urandom_range(0, MAX_TAPS - 1), rand_coef());
      else push_sample(rand_sample());
    end
  endtask

  // Wait until every beat is taken and every result is back, then let the block drain.
  task automatic settle();
    while (!(beats_taken == beats_pushed && want_filtered.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme coefficients and samples on a short filter with no decimation.
    write_reg(CFG_SPARE, 9'h1FF);
    write_reg(CFG_DECIMATION, 9'd1);
    write_reg(CFG_TAP_COUNT, 9'd4);
    push_coef(0, 18'sh1FFFF);
    push_coef(1, 18'sh20000);
    push_coef(2, 18'sh00000);
    push_coef(3, 18'sh3FFFF);
    push_coef(MAX_TAPS - 1, 18'sh20000);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh0001);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    settle();

    // Zero settings act as one; the receiver holds off so the input backs up.
    write_reg(CFG_DECIMATION, 9'h1E0);
    write_reg(CFG_TAP_COUNT, 9'h000);
    rx_hold_req = 1'b1;
    run_random(60);
    settle();

    // Full-length filter, every sample kept, driven into both saturation rails.
    write_reg(CFG_TAP_COUNT, 9'h100);
    write_reg(CFG_DECIMATION, 9'h001);
    for (int j = 0; j < MAX_TAPS; j++) push_coef(j, 18'sh1FFFF);
    repeat (20) push_sample(16'sh7FFF);
    repeat (20) push_sample(16'sh8000);
    run_random(40);
    settle();

    // Settings above range clamp to the maximum decimation and tap count.
    write_reg(CFG_DECIMATION, 9'h1FF);
    write_reg(CFG_TAP_COUNT, 9'h1FF);
    run_random(80);
    settle();

    // Reset values; the phase count left over carries into the new factor.
    // Midway, the sender stops until all results are back.
    write_reg(CFG_DECIMATION, 9'd4);
    write_reg(CFG_TAP_COUNT, 9'd193);
    run_random(30);
    while (!(beats_taken == beats_pushed && want_filtered.size() == 0)) @(posedge clk);
    run_random(30);
    settle();

    write_reg(CFG_TAP_COUNT, 9'd17);
    write_reg(CFG_DECIMATION, 9'd3);
    run_random(60);
    settle();

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    write_reg(CFG_TAP_COUNT, 9'd8);
    write_reg(CFG_DECIMATION, 9'd2);
    run_random(50);
    settle();

    if (want_filtered.size() != 0) begin
      errors++;
      $display("%0t: %0d filtered values never arrived", $time, want_filtered.size());
    end
    $display("Run covered %0d input beats (%0d coefficient loads) and %0d filtered results,",
             beats_taken, coef_beats, results_seen);
    $display("  %0d clipped, over %0d register writes spanning decimation 1..16, 1..256 taps.",
             sat_hits, cfg_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
